>>> rtl/core/sbsi_pkg.sv
// ----------------------------------------------------------------------------
// Segment/box slab test package
// Shared widths, defaults and reset values for the slab intersection core.
// ----------------------------------------------------------------------------
package sbsi_pkg;

  localparam int COORD_W             = 32;
  localparam int EPS_W               = 16;
  localparam int EPS2_W              = 2 * EPS_W;
  localparam int SQ_W                = 2 * COORD_W;
  localparam int NUM_AXES            = 3;
  localparam int DEF_PARAM_FRAC_BITS = 16;

  localparam logic [EPS_W-1:0]  EPS_RESET  = EPS_W'(4295);
  localparam logic [EPS2_W-1:0] EPS2_RESET = EPS2_W'(18447025);

endpackage

>>> rtl/core/segment_box_slab_intersect_core.sv
// ----------------------------------------------------------------------------
// Segment versus box slab intersection core
// Three axis lanes, a parallel-axis threshold path and a merging stage.
// ----------------------------------------------------------------------------
// The core takes one request per cycle while in_ready is high and
// returns each result in order. The pipeline depth is set by the slab
// dividers, which produce one quotient bit per stage. Only the output
// register holds the pipeline back: while a result waits there, new
// requests are still taken as long as the last pipeline stage is empty.
// The epsilon register is squared when written, so it should be written
// only while no request is in flight.
module segment_box_slab_intersect_core import sbsi_pkg::*; #(
  parameter int PARAM_FRAC_BITS = DEF_PARAM_FRAC_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       parallel_epsilon_we,
  input  logic [EPS_W-1:0]           parallel_epsilon,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [COORD_W-1:0]  start_x,
  input  logic signed [COORD_W-1:0]  start_y,
  input  logic signed [COORD_W-1:0]  start_z,
  input  logic signed [COORD_W-1:0]  end_x,
  input  logic signed [COORD_W-1:0]  end_y,
  input  logic signed [COORD_W-1:0]  end_z,
  input  logic signed [COORD_W-1:0]  box_min_x,
  input  logic signed [COORD_W-1:0]  box_min_y,
  input  logic signed [COORD_W-1:0]  box_min_z,
  input  logic signed [COORD_W-1:0]  box_max_x,
  input  logic signed [COORD_W-1:0]  box_max_y,
  input  logic signed [COORD_W-1:0]  box_max_z,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       hit,
  output logic [PARAM_FRAC_BITS:0]   entry_param
);

  localparam int P    = PARAM_FRAC_BITS;
  localparam int LAST = P + 6;
  localparam int TW   = P + 3;
  localparam int SW   = SQ_W + 2;
  localparam int PW   = EPS2_W + 33;
  localparam int FW   = PW + 33;
  localparam int THW  = FW - 64 + 1;

  logic en;
  logic [LAST:1] vld;
  logic [EPS2_W-1:0] eps2;

  logic signed [COORD_W-1:0] s_r  [NUM_AXES];
  logic signed [COORD_W-1:0] e_r  [NUM_AXES];
  logic signed [COORD_W-1:0] lo_r [NUM_AXES];
  logic signed [COORD_W-1:0] hi_r [NUM_AXES];

  logic            outside [NUM_AXES];
  logic [SQ_W-1:0] sq      [NUM_AXES];
  logic signed [TW-1:0] t_near [NUM_AXES];
  logic signed [TW-1:0] t_far  [NUM_AXES];

  logic [SQ_W-1:0] sq4 [NUM_AXES];
  logic [SQ_W-1:0] sq5 [NUM_AXES];
  logic [SQ_W-1:0] sq6 [NUM_AXES];
  logic [SW-1:0]   sum;
  logic [PW-1:0]   pa;
  logic [PW-1:0]   pb;
  logic [FW-1:0]   tot;
  logic [THW-1:0]  thr;

  logic [NUM_AXES-1:0] outs [3:LAST];
  logic [NUM_AXES-1:0] pars [7:LAST];
  logic [NUM_AXES-1:0] par_now;
  logic [NUM_AXES-1:0] out_now;

  logic signed [TW-1:0] tmin;
  logic signed [TW-1:0] tmax;
  logic                 miss;
  logic                 hit_next;
  logic [P:0]           entry_next;

  assign en       = !(out_valid && !out_ready && vld[LAST]);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps2 <= EPS2_RESET;
    end else if (parallel_epsilon_we) begin
      eps2 <= EPS2_W'(parallel_epsilon) * EPS2_W'(parallel_epsilon);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAST-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r[0]  <= start_x;
      s_r[1]  <= start_y;
      s_r[2]  <= start_z;
      e_r[0]  <= end_x;
      e_r[1]  <= end_y;
      e_r[2]  <= end_z;
      lo_r[0] <= box_min_x;
      lo_r[1] <= box_min_y;
      lo_r[2] <= box_min_z;
      hi_r[0] <= box_max_x;
      hi_r[1] <= box_max_y;
      hi_r[2] <= box_max_z;
    end
  end

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    sbsi_lane #(.PARAM_FRAC_BITS(P)) u_lane (
      .clk     (clk),
      .en      (en),
      .s       (s_r[i]),
      .e       (e_r[i]),
      .lo      (lo_r[i]),
      .hi      (hi_r[i]),
      .outside (outside[i]),
      .sq      (sq[i]),
      .t_near  (t_near[i]),
      .t_far   (t_far[i])
    );

    always_ff @(posedge clk) begin
      if (en) begin
        sq4[i] <= sq[i];
        sq5[i] <= sq4[i];
        sq6[i] <= sq5[i];
      end
    end

    always_comb begin
      out_now[i] = outside[i];
      par_now[i] = (sq6[i] == '0) || (sq6[i] < SQ_W'(thr));
    end
  end

  // The threshold is ceil(eps^2 * |d|^2 / 2^64), built from two half products.
  always_comb begin
    tot = {pa, 33'b0} + FW'(pb);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
      pa  <= PW'(eps2) * PW'(sum[SW-1:33]);
      pb  <= PW'(eps2) * PW'(sum[32:0]);
      thr <= THW'(tot[FW-1:64]) + THW'(|tot[63:0]);
      outs[3] <= out_now;
      pars[7] <= par_now;
      for (int k = 4; k <= LAST; k++) begin
        outs[k] <= outs[k-1];
      end
      for (int k = 8; k <= LAST; k++) begin
        pars[k] <= pars[k-1];
      end
    end
  end

  always_comb begin
    tmin = '0;
    tmax = TW'(1) << P;
    miss = 1'b0;
    for (int i = 0; i < NUM_AXES; i++) begin
      if (pars[LAST][i]) begin
        miss = miss | outs[LAST][i];
      end else begin
        if (t_near[i] > tmin) begin
          tmin = t_near[i];
        end
        if (t_far[i] < tmax) begin
          tmax = t_far[i];
        end
      end
    end
    hit_next   = !miss && (tmin <= tmax);
    entry_next = hit_next ? tmin[P:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en && vld[LAST]) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld[LAST]) begin
      hit         <= hit_next;
      entry_param <= entry_next;
    end
  end

endmodule

>>> rtl/core/sbsi_div.sv
// ----------------------------------------------------------------------------
// Pipelined slab divider
// Computes floor(num * 2^P / den) saturated to +-2^(P+1), one quotient bit
// per stage, restoring form.
// ----------------------------------------------------------------------------
module sbsi_div import sbsi_pkg::*; #(
  parameter int PARAM_FRAC_BITS = DEF_PARAM_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [COORD_W:0]           num,
  input  logic signed [COORD_W:0]           den,
  output logic signed [PARAM_FRAC_BITS+2:0] quot
);

  localparam int P  = PARAM_FRAC_BITS;
  localparam int NW = COORD_W + 1;
  localparam int QW = P + 1;

  logic [NW-1:0] num_abs;
  logic [NW-1:0] den_abs;
  logic [NW-1:0] an;
  logic [NW-1:0] ad;
  logic          neg;
  logic          sat;

  logic [NW-1:0] rem [0:P];
  logic [QW-1:0] qb  [0:P];
  logic [NW-1:0] dv  [0:P];
  logic          ng  [0:P];
  logic          st  [0:P];

  logic [P+1:0]  mag;

  always_comb begin
    num_abs = num[NW-1] ? NW'(-num) : NW'(num);
    den_abs = den[NW-1] ? NW'(-den) : NW'(den);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      an  <= num_abs;
      ad  <= den_abs;
      neg <= num[NW-1] ^ den[NW-1];
      sat <= {1'b0, num_abs} >= {den_abs, 1'b0};
    end
  end

  for (genvar k = 0; k <= P; k++) begin : g_step
    logic [NW:0]   rr;
    logic [NW-1:0] dd;
    logic [NW:0]   diff;
    logic          ge;

    if (k == 0) begin : g_first
      always_comb begin
        rr = {1'b0, an};
        dd = ad;
      end
      always_ff @(posedge clk) begin
        if (en) begin
          qb[k] <= {{(QW-1){1'b0}}, ge};
          ng[k] <= neg;
          st[k] <= sat;
        end
      end
    end else begin : g_next
      always_comb begin
        rr = {rem[k-1], 1'b0};
        dd = dv[k-1];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          qb[k] <= {qb[k-1][QW-2:0], ge};
          ng[k] <= ng[k-1];
          st[k] <= st[k-1];
        end
      end
    end

    always_comb begin
      diff = rr - {1'b0, dd};
      ge   = rr >= {1'b0, dd};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? diff[NW-1:0] : rr[NW-1:0];
        dv[k]  <= dd;
      end
    end
  end

  always_comb begin
    if (st[P]) begin
      mag = (P+2)'(1) << (P + 1);
    end else begin
      mag = {1'b0, qb[P]} + (P+2)'(ng[P] && (rem[P] != '0));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quot <= ng[P] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

endmodule

>>> rtl/core/sbsi_lane.sv
// ----------------------------------------------------------------------------
// Slab test lane
// One axis: direction, squared length term, slab containment and the two
// ordered slab hit parameters.
// ----------------------------------------------------------------------------
module sbsi_lane import sbsi_pkg::*; #(
  parameter int PARAM_FRAC_BITS = DEF_PARAM_FRAC_BITS
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [COORD_W-1:0]         s,
  input  logic signed [COORD_W-1:0]         e,
  input  logic signed [COORD_W-1:0]         lo,
  input  logic signed [COORD_W-1:0]         hi,
  output logic                              outside,
  output logic [SQ_W-1:0]                   sq,
  output logic signed [PARAM_FRAC_BITS+2:0] t_near,
  output logic signed [PARAM_FRAC_BITS+2:0] t_far
);

  localparam int NW = COORD_W + 1;

  logic signed [NW-1:0] d;
  logic signed [NW-1:0] num_lo;
  logic signed [NW-1:0] num_hi;
  logic [COORD_W-1:0]   d_abs;

  logic signed [PARAM_FRAC_BITS+2:0] t1;
  logic signed [PARAM_FRAC_BITS+2:0] t2;

  always_ff @(posedge clk) begin
    if (en) begin
      d       <= $signed({e[COORD_W-1], e}) - $signed({s[COORD_W-1], s});
      num_lo  <= $signed({lo[COORD_W-1], lo}) - $signed({s[COORD_W-1], s});
      num_hi  <= $signed({hi[COORD_W-1], hi}) - $signed({s[COORD_W-1], s});
      outside <= (s < lo) || (s > hi);
    end
  end

  always_comb begin
    d_abs = d[NW-1] ? COORD_W'(-d) : COORD_W'(d);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq <= SQ_W'(d_abs) * SQ_W'(d_abs);
    end
  end

  sbsi_div #(.PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_div_lo (
    .clk  (clk),
    .en   (en),
    .num  (num_lo),
    .den  (d),
    .quot (t1)
  );

  sbsi_div #(.PARAM_FRAC_BITS(PARAM_FRAC_BITS)) u_div_hi (
    .clk  (clk),
    .en   (en),
    .num  (num_hi),
    .den  (d),
    .quot (t2)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      t_near <= (t1 > t2) ? t2 : t1;
      t_far  <= (t1 > t2) ? t1 : t2;
    end
  end

endmodule

>>> rtl/core/sbsi_checker.sv
// ----------------------------------------------------------------------------
// Slab intersection port checker
// Watches the ports of the core for result and flow-control consistency.
// ----------------------------------------------------------------------------
module sbsi_checker import sbsi_pkg::*; #(
  parameter int PARAM_FRAC_BITS = DEF_PARAM_FRAC_BITS
) (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     hit,
  input logic [PARAM_FRAC_BITS:0] entry_param
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(entry_param))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit |-> entry_param == '0)
    else $error("miss with nonzero entry parameter");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> entry_param <= ((PARAM_FRAC_BITS+1)'(1) << PARAM_FRAC_BITS))
    else $error("entry parameter above one");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("request refused without a blocked result");

endmodule

bind segment_box_slab_intersect_core sbsi_checker #(
  .PARAM_FRAC_BITS(PARAM_FRAC_BITS)
) u_sbsi_checker (.*);
